// File: sv/fbd_pkg.sv
// ---------------------------------------------------------------------------
// fbd_pkg
// Types, constants and AES helper functions shared by the block decrypt core
// ---------------------------------------------------------------------------
package fbd_pkg;

    localparam int ADDRESS_BITS_DEF = 24;
    localparam int TWEAK_SHIFT      = 5;
    localparam int KEY_BITS         = 256;
    localparam int BLOCK_BITS       = 128;
    localparam int REG_BITS         = 64;
    localparam int NUM_ROUNDS       = 14;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [1:0] {
        REG_KEY_01 = 2'd0,
        REG_KEY_23 = 2'd1,
        REG_KEY_45 = 2'd2,
        REG_KEY_67 = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic                  status;
        logic [BLOCK_BITS-1:0] state;
        logic [KEY_BITS-1:0]   key;
    } t_item;

    localparam logic [31:0] MUL_A [8] = '{
        32'h00800010, 32'h00000400, 32'h00400008, 32'h00000200,
        32'h00800010, 32'h00000400, 32'h04000080, 32'h00002000
    };
    localparam logic [31:0] MUL_B [8] = '{
        32'h00000001, 32'h20000000, 32'h00000000, 32'h10000000,
        32'h00000000, 32'h20000000, 32'h00000000, 32'h00000000
    };
    localparam logic [KEY_BITS-1:0] MUL_B_MASK = {
        32'h00000000, 32'h0000007F, 32'hE0000000, 32'h0000000F,
        32'hF0000000, 32'h00000007, 32'hE0000000, 32'h0000000F
    };

    localparam logic [7:0] RCON [8] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [BLOCK_BITS-1:0] aes_round(
        input logic [BLOCK_BITS-1:0] s,
        input logic [BLOCK_BITS-1:0] rk,
        input logic                  last
    );
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] m [16];
        logic [7:0] all;
        logic [BLOCK_BITS-1:0] r;
        for (int k = 0; k < 16; k++) begin
            t[k] = SBOX[s[127-8*k -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                b[i+4*c] = t[i+4*((c+i)%4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = b[4*c] ^ b[4*c+1] ^ b[4*c+2] ^ b[4*c+3];
            m[4*c]   = b[4*c]   ^ all ^ xtime(b[4*c]   ^ b[4*c+1]);
            m[4*c+1] = b[4*c+1] ^ all ^ xtime(b[4*c+1] ^ b[4*c+2]);
            m[4*c+2] = b[4*c+2] ^ all ^ xtime(b[4*c+2] ^ b[4*c+3]);
            m[4*c+3] = b[4*c+3] ^ all ^ xtime(b[4*c+3] ^ b[4*c]);
        end
        for (int k = 0; k < 16; k++) begin
            r[127-8*k -: 8] = (last ? b[k] : m[k]) ^ rk[127-8*k -: 8];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_BITS-1:0] next_round_key(
        input logic [KEY_BITS-1:0] win,
        input logic                rot,
        input logic [7:0]          rc
    );
        logic [31:0] g;
        logic [31:0] lw;
        logic [31:0] n0, n1, n2, n3;
        lw = win[31:0];
        if (rot) begin
            g = {SBOX[lw[23:16]] ^ rc, SBOX[lw[15:8]], SBOX[lw[7:0]], SBOX[lw[31:24]]};
        end else begin
            g = {SBOX[lw[31:24]], SBOX[lw[23:16]], SBOX[lw[15:8]], SBOX[lw[7:0]]};
        end
        n0 = win[255:224] ^ g;
        n1 = win[223:192] ^ n0;
        n2 = win[191:160] ^ n1;
        n3 = win[159:128] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

// File: sv/fbd_front.sv
// ---------------------------------------------------------------------------
// fbd_front
// Accepts blocks, flags misaligned addresses and builds the tweaked key
// ---------------------------------------------------------------------------
module fbd_front #(
    parameter int ADDRESS_BITS = fbd_pkg::ADDRESS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ADDRESS_BITS-1:0]       i_block_address,
    input  logic [63:0]                   i_cipher_low,
    input  logic [63:0]                   i_cipher_high,
    input  logic [fbd_pkg::KEY_BITS-1:0]  i_base_key,
    output logic                          o_push,
    output fbd_pkg::t_item                o_item,
    input  logic                          i_full
);
    import fbd_pkg::*;

    localparam int TW = ADDRESS_BITS - TWEAK_SHIFT;
    localparam int PW = 32 + TW;

    logic                  en;
    logic [TW-1:0]         tweak;
    logic                  r_va, n_va;
    logic                  r_mis;
    logic [BLOCK_BITS-1:0] r_cipher;
    logic [PW-1:0]         r_pa [8];
    logic [PW-1:0]         r_pb [8];
    logic                  r_vb, n_vb;
    t_item                 r_item;
    logic [KEY_BITS-1:0]   ea, oa, eb, ob;

    assign en         = !(r_vb && i_full);
    assign o_in_stall = !en;
    assign tweak      = i_block_address[ADDRESS_BITS-1:TWEAK_SHIFT];
    assign n_va       = i_in_valid;
    assign n_vb       = r_va;

    // even and odd limb products do not overlap within their group
    assign ea = {64'(r_pa[6]), 64'(r_pa[4]), 64'(r_pa[2]), 64'(r_pa[0])};
    assign oa = {64'(r_pa[7]), 64'(r_pa[5]), 64'(r_pa[3]), 64'(r_pa[1])} << 32;
    assign eb = {64'(r_pb[6]), 64'(r_pb[4]), 64'(r_pb[2]), 64'(r_pb[0])};
    assign ob = {64'(r_pb[7]), 64'(r_pb[5]), 64'(r_pb[3]), 64'(r_pb[1])} << 32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (en) begin
            r_va <= n_va;
            r_vb <= n_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mis    <= (i_block_address[3:0] != 4'd0);
            r_cipher <= {i_cipher_high, i_cipher_low};
            for (int i = 0; i < 8; i++) begin
                r_pa[i] <= PW'(MUL_A[i]) * PW'(tweak);
                r_pb[i] <= PW'(MUL_B[i]) * PW'(tweak);
            end
            r_item.status <= r_mis;
            r_item.state  <= r_cipher;
            r_item.key    <= i_base_key ^ ((ea + oa) | ((eb + ob) & MUL_B_MASK));
        end
    end

    assign o_push = r_vb && en;
    assign o_item = r_item;

endmodule

// File: sv/fbd_queue.sv
// ---------------------------------------------------------------------------
// fbd_queue
// Short request queue between the key front end and the cipher pipeline
// ---------------------------------------------------------------------------
module fbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fbd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fbd_pkg::t_item o_item
);
    import fbd_pkg::*;

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PTRW-1:0] r_wr, n_wr;
    logic [PTRW-1:0] r_rd, n_rd;
    logic [CNTW-1:0] r_count, n_count;

    assign o_full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTRW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: sv/fbd_back.sv
// ---------------------------------------------------------------------------
// fbd_back
// Fully unrolled AES-256 pipeline with on-the-fly key expansion
// ---------------------------------------------------------------------------
module fbd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fbd_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [63:0]    o_plain_low,
    output logic [63:0]    o_plain_high,
    output logic           o_status
);
    import fbd_pkg::*;

    localparam int LAST = NUM_ROUNDS;

    logic                  en;
    logic                  r_v  [LAST+1];
    logic                  r_st [LAST+1];
    logic [BLOCK_BITS-1:0] r_s  [LAST+1];
    logic [KEY_BITS-1:0]   r_k  [LAST];
    logic [BLOCK_BITS-1:0] n_s  [LAST+1];
    logic [KEY_BITS-1:0]   n_k  [LAST];

    assign en    = !r_v[LAST] || !i_out_stall;
    assign o_pop = en && i_valid;

    assign n_s[0] = i_item.state ^ i_item.key[255:128];
    assign n_k[0] = i_item.key;

    for (genvar r = 1; r <= LAST; r++) begin : g_round
        if (r == LAST) begin : g_final
            assign n_s[r] = r_st[r-1] ? '0 : aes_round(r_s[r-1], r_k[r-1][127:0], 1'b1);
        end else begin : g_mid
            assign n_s[r] = aes_round(r_s[r-1], r_k[r-1][127:0], 1'b0);
            assign n_k[r] = {r_k[r-1][127:0],
                             next_round_key(r_k[r-1], (r % 2) == 1, RCON[((r + 2) / 2) % 8])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r <= LAST; r++) begin
                r_v[r] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int r = 1; r <= LAST; r++) begin
                r_v[r] <= r_v[r-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= i_item.status;
            for (int r = 1; r <= LAST; r++) begin
                r_st[r] <= r_st[r-1];
            end
            for (int r = 0; r <= LAST; r++) begin
                r_s[r] <= n_s[r];
            end
            for (int r = 0; r < LAST; r++) begin
                r_k[r] <= n_k[r];
            end
        end
    end

    assign o_out_valid  = r_v[LAST];
    assign o_status     = r_st[LAST];
    assign o_plain_high = r_s[LAST][127:64];
    assign o_plain_low  = r_s[LAST][63:0];

endmodule

// File: sv/flash_block_decrypt.sv
// ---------------------------------------------------------------------------
// flash_block_decrypt
// Address-tweaked AES-256 decryption of one 16-byte flash block per request
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | i_in_valid / o_in_stall   | block_address, cipher_low/high
//  output   | o_out_valid / i_out_stall | plain_low/high, status
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  one request per cycle sustained when neither side stalls; the path is
//  two front stages (tweak products, key sum), one queue slot, fifteen cipher
//  stages (initial key add and fourteen rounds, the last one is the output).
//  reset clears control state and the key registers, nothing else.
//  an output stall freezes the cipher pipeline; the two-entry queue absorbs
//  the front, which stalls its input only once the queue is full.
// ---------------------------------------------------------------------------
module flash_block_decrypt #(
    parameter int ADDRESS_BITS = fbd_pkg::ADDRESS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [ADDRESS_BITS-1:0] i_block_address,
    input  logic [63:0]             i_cipher_low,
    input  logic [63:0]             i_cipher_high,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [63:0]             o_plain_low,
    output logic [63:0]             o_plain_high,
    output logic                    o_status,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data
);
    import fbd_pkg::*;

    logic [REG_BITS-1:0] r_key [4];
    logic [KEY_BITS-1:0] base_key;
    logic                push, full, pop, q_valid;
    t_item               f_item, q_item;

    assign base_key = {r_key[3], r_key[2], r_key[1], r_key[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_KEY_01: r_key[0] <= i_cfg_data;
                REG_KEY_23: r_key[1] <= i_cfg_data;
                REG_KEY_45: r_key[2] <= i_cfg_data;
                REG_KEY_67: r_key[3] <= i_cfg_data;
                default:    r_key[0] <= r_key[0];
            endcase
        end
    end

    fbd_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_block_address (i_block_address),
        .i_cipher_low    (i_cipher_low),
        .i_cipher_high   (i_cipher_high),
        .i_base_key      (base_key),
        .o_push          (push),
        .o_item          (f_item),
        .i_full          (full)
    );

    fbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_plain_low  (o_plain_low),
        .o_plain_high (o_plain_high),
        .o_status     (o_status)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("push into full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_plain_low == 64'd0 && o_plain_high == 64'd0))
        else $error("misaligned request with nonzero data");

endmodule
